// File: src/time_bracket_interpolation_factor_top_assert.svh
// Assertion macros for the time bracket block and its checker.
`ifndef TIME_BRACKET_INTERPOLATION_FACTOR_TOP_ASSERT_SVH
`define TIME_BRACKET_INTERPOLATION_FACTOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define TBIF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbif assertion failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define TBIF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbif assertion failed");

`endif

// File: src/tbif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbif_pkg;

    localparam int MAX_TIMES   = 64;
    localparam int IDX_W       = $clog2(MAX_TIMES);
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_W      = FRAC_BITS + 1;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    // 1.0 in the fraction format
    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      operation;
        logic [IDX_W-1:0]         entry_index;
        logic signed [TIME_W-1:0] time_value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]  lower_index;
        logic [IDX_W-1:0]  upper_index;
        logic [FRAC_W-1:0] fraction;
        logic              indices_changed;
    } t_out_item;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic             valid;
        t_in_item         item;
        logic [IDX_W-1:0] last_index;
    } t_queue_head;

endpackage

`default_nettype wire

// File: src/tbif_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tbif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: src/tbif_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tbif_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire tbif_pkg::t_in_item          i_item,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [tbif_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_pop,
    output tbif_pkg::t_queue_head            o_head
);

    localparam int PTR_W = (tbif_pkg::QUEUE_DEPTH > 1) ? $clog2(tbif_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tbif_pkg::QUEUE_DEPTH + 1);

    tbif_pkg::t_in_item                r_q_item [tbif_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]                  r_wr_ptr;
    logic [PTR_W-1:0]                  r_rd_ptr;
    logic [CNT_W-1:0]                  r_count;
    logic [tbif_pkg::CFG_W-1:0]        r_times_in_use;
    logic [tbif_pkg::IDX_W-1:0]        last_index;
    logic                              push;
    logic                              pop;

    assign busy        = (r_count == CNT_W'(tbif_pkg::QUEUE_DEPTH));
    assign push        = start && !busy;
    assign pop         = i_pop && (r_count != '0);
    assign o_cfg_ready = 1'b1;

    // Clamp the entry count to 1..MAX_TIMES and turn it into the last index
    always_comb begin
        if (r_times_in_use == '0) begin
            last_index = '0;
        end else if (r_times_in_use > tbif_pkg::CFG_W'(tbif_pkg::MAX_TIMES)) begin
            last_index = tbif_pkg::IDX_W'(tbif_pkg::MAX_TIMES - 1);
        end else begin
            last_index = tbif_pkg::IDX_W'(r_times_in_use - tbif_pkg::CFG_W'(1));
        end
    end

    // Present the oldest item with its clamped table bound
    always_comb begin
        o_head.valid      = (r_count != '0);
        o_head.item       = r_q_item[r_rd_ptr];
        o_head.last_index = last_index;
    end

    // Hold the entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_times_in_use <= tbif_pkg::CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_times_in_use <= i_cfg_data;
        end
    end

    // Store accepted items
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_item[r_wr_ptr] <= i_item;
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(tbif_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(tbif_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/tbif_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tbif_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tbif_pkg::t_queue_head i_head,
    output logic                       o_pop,
    output logic                       o_strobe,
    output tbif_pkg::t_out_item        o_result
);

    localparam int IDX_W  = tbif_pkg::IDX_W;
    localparam int TIME_W = tbif_pkg::TIME_W;
    localparam int BIT_W  = (tbif_pkg::FRAC_BITS > 1) ? $clog2(tbif_pkg::FRAC_BITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK0,
        S_WALK,
        S_SPAN,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic signed [TIME_W-1:0]        r_time;
    logic signed [TIME_W-1:0]        r_lo;
    logic signed [TIME_W-1:0]        r_hi;
    logic [IDX_W-1:0]                r_i;
    logic [IDX_W-1:0]                r_last;
    logic signed [TIME_W:0]          r_num;
    logic signed [TIME_W:0]          r_den;
    logic [TIME_W:0]                 r_rem;
    logic [tbif_pkg::FRAC_BITS-1:0]  r_quo;
    logic [BIT_W-1:0]                r_bit;
    logic [IDX_W-1:0]                r_lower;
    logic [IDX_W-1:0]                r_upper;
    logic [tbif_pkg::FRAC_W-1:0]     r_frac;
    logic [IDX_W-1:0]                r_prev_lower;
    logic [IDX_W-1:0]                r_prev_upper;
    logic                            r_pair_valid;

    logic                            wr_en;
    logic [IDX_W-1:0]                rd_addr;
    logic [TIME_W-1:0]               rd_data;
    logic signed [TIME_W-1:0]        rd_time;
    logic signed [TIME_W:0]          span_num;
    logic signed [TIME_W:0]          span_den;
    logic [TIME_W+1:0]               div_shift;
    logic [TIME_W+1:0]               div_den;
    logic                            div_take;
    logic [TIME_W+1:0]               div_diff;
    logic [tbif_pkg::FRAC_BITS-1:0]  n_quo;

    // Pop whenever the back end is free; loads finish in the pop cycle
    assign o_pop   = (r_state == S_IDLE) && i_head.valid;
    assign wr_en   = o_pop && (i_head.item.operation == tbif_pkg::OP_LOAD);
    assign rd_time = $signed(rd_data);

    // Read address: first entry at pop, then the entry after the lower one
    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = '0;
            S_CHK0:  rd_addr = IDX_W'(1);
            S_WALK:  rd_addr = r_i + IDX_W'(2);
            default: rd_addr = '0;
        endcase
    end

    tbif_ram #(
        .WIDTH (TIME_W),
        .DEPTH (tbif_pkg::MAX_TIMES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_head.item.entry_index),
        .i_wr_data (i_head.item.time_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Span of the bracket and the query offset into it
    assign span_num = {r_time[TIME_W-1], r_time} - {r_lo[TIME_W-1], r_lo};
    assign span_den = {r_hi[TIME_W-1], r_hi} - {r_lo[TIME_W-1], r_lo};

    // One restoring division step
    assign div_shift = {r_rem, 1'b0};
    assign div_den   = {1'b0, r_den};
    assign div_take  = (div_shift >= div_den);
    assign div_diff  = div_shift - div_den;
    assign n_quo     = {r_quo[tbif_pkg::FRAC_BITS-2:0], div_take};

    // Sequence the query: first entry check, walk, span, range check, divide, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            o_strobe     <= 1'b0;
            r_prev_lower <= '0;
            r_prev_upper <= '0;
            r_pair_valid <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_head.item.operation == tbif_pkg::OP_QUERY)) begin
                        r_time  <= i_head.item.time_value;
                        r_last  <= i_head.last_index;
                        r_state <= S_CHK0;
                    end
                end
                S_CHK0: begin
                    if (r_time < rd_time) begin
                        r_lower <= '0;
                        r_upper <= '0;
                        r_frac  <= '0;
                        r_state <= S_OUT;
                    end else if (r_last == '0) begin
                        r_lower <= '0;
                        r_upper <= '0;
                        r_frac  <= tbif_pkg::FRAC_ONE;
                        r_state <= S_OUT;
                    end else begin
                        r_lo    <= rd_time;
                        r_i     <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_time <= rd_time) begin
                        r_hi    <= rd_time;
                        r_lower <= r_i;
                        r_upper <= r_i + IDX_W'(1);
                        r_state <= S_SPAN;
                    end else if (r_i + IDX_W'(1) == r_last) begin
                        r_lower <= r_last;
                        r_upper <= r_last;
                        r_frac  <= tbif_pkg::FRAC_ONE;
                        r_state <= S_OUT;
                    end else begin
                        r_lo <= rd_time;
                        r_i  <= r_i + IDX_W'(1);
                    end
                end
                S_SPAN: begin
                    r_num   <= span_num;
                    r_den   <= span_den;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if ((r_den <= 0) || (r_num <= 0)) begin
                        r_frac  <= '0;
                        r_state <= S_OUT;
                    end else if (r_num >= r_den) begin
                        r_frac  <= tbif_pkg::FRAC_ONE;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= r_num;
                        r_quo   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_take ? div_diff[TIME_W:0] : div_shift[TIME_W:0];
                    r_quo <= n_quo;
                    r_bit <= r_bit + BIT_W'(1);
                    if (r_bit == BIT_W'(tbif_pkg::FRAC_BITS - 1)) begin
                        r_frac  <= {1'b0, n_quo};
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_strobe                 <= 1'b1;
                    o_result.lower_index     <= r_lower;
                    o_result.upper_index     <= r_upper;
                    o_result.fraction        <= r_frac;
                    o_result.indices_changed <= !r_pair_valid ||
                                                (r_lower != r_prev_lower) ||
                                                (r_upper != r_prev_upper);
                    r_prev_lower             <= r_lower;
                    r_prev_upper             <= r_upper;
                    r_pair_valid             <= 1'b1;
                    r_state                  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/time_bracket_interpolation_factor_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// item      in         start high, busy low       i_item (t_in_item)
// result    out        o_strobe, one cycle        o_result (t_out_item)
// config    in         i_cfg_valid, o_cfg_ready   i_cfg_data (entries in use)
//
// A load finishes in the back end in its pop cycle. A query ends after the
// first entry check when it lands before the first entry or the table holds
// one entry; else it walks the table through the single RAM read port, and
// when it finds a bracket it does the span and range check and then a
// bit-serial division when the fraction lies strictly inside it. Two items
// queue ahead of the back end; busy is high while that queue is full.
// Reset is synchronous and clears the queue, the sequencer and the previous
// pair; the table keeps its contents.
// A result is shown for one cycle and cannot be held off.
module time_bracket_interpolation_factor_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire tbif_pkg::t_in_item          i_item,
    output logic                             o_strobe,
    output tbif_pkg::t_out_item              o_result,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [tbif_pkg::CFG_W-1:0]  i_cfg_data
);

    tbif_pkg::t_queue_head head;
    logic                  pop;

    tbif_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (pop),
        .o_head      (head)
    );

    tbif_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: src/tbif_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "time_bracket_interpolation_factor_top_assert.svh"

module tbif_props (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire tbif_pkg::t_in_item          i_item,
    input wire logic                        o_strobe,
    input wire tbif_pkg::t_out_item         o_result,
    input wire logic                        i_cfg_valid,
    input wire logic                        o_cfg_ready,
    input wire logic [tbif_pkg::CFG_W-1:0]  i_cfg_data
);

    logic frac_ok;
    logic frac_edge;
    logic pair_clamped;
    logic pair_adjacent;

    // Classify the fraction and the pair shown on the result ports
    assign frac_ok       = (o_result.fraction <= tbif_pkg::FRAC_ONE);
    assign frac_edge     = (o_result.fraction == '0) ||
                           (o_result.fraction == tbif_pkg::FRAC_ONE);
    assign pair_clamped  = (o_result.upper_index == o_result.lower_index);
    assign pair_adjacent = (o_result.upper_index ==
                            o_result.lower_index + tbif_pkg::IDX_W'(1));

    // Fraction never passes 1.0
    `TBIF_ASSERT_IMPL(a_frac_range, i_clk, i_rst_n, o_strobe, frac_ok)

    // Pair is either clamped to one entry or two neighbors
    `TBIF_ASSERT_IMPL(a_pair_adjacent, i_clk, i_rst_n, o_strobe, pair_clamped || pair_adjacent)

    // Clamped pair gives exactly 0 or 1.0
    `TBIF_ASSERT_IMPL(a_clamp_frac, i_clk, i_rst_n, o_strobe && pair_clamped, frac_edge)

    // The back end returns to idle after each result, so results never come back to back
    `TBIF_ASSERT_NEXT(a_no_back_to_back, i_clk, i_rst_n, o_strobe, !o_strobe)

endmodule

bind time_bracket_interpolation_factor_top tbif_props u_tbif_checker (.*);

`default_nettype wire
